// File: src/btn_edge_pkg.sv
// shared constants and operation codes for the button edge latch register block
package btn_edge_pkg;

  localparam int WORD_W = 16;
  localparam int DEFAULT_BUTTON_COUNT = 16;
  localparam int OP_W = 2;
  localparam int COUNT_W = 3;

  // stream widths, fields packed from bit 0 up and padded to whole bytes
  localparam int IN_FIELDS_W = 3 * WORD_W + COUNT_W;
  localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 7 * WORD_W + 2;
  localparam int OUT_DATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  // write lengths in bytes
  localparam logic [COUNT_W-1:0] LAMP_BYTES = 3'd2;
  localparam logic [COUNT_W-1:0] FULL_BYTES = 3'd4;

  typedef enum logic [OP_W-1:0] {
    OP_SCAN  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_ACK   = 2'd3
  } op_t;

endpackage

// File: src/button_edge_latch_register_block.sv
// top level of the button edge latch register block
//
// register block of a button and lamp panel slave, worked at 16-bit word level. every input
// item is one operation selected by s_tuser: a scan sample (a changed sample updates the
// button levels, ors rising and falling edges into sticky latches and raises the interrupt),
// a master read (reports levels and latched edges, then clears latches and interrupt), a
// master write (two or more bytes take the lamp word, four also the active word; a change
// saves the old words and sets the update flag) or an acknowledge that clears the update
// flag. each item gives exactly one result item carrying the full register view after the
// operation, except that a read reports the edge latches as they were before clearing.
// throughput is one item per clock while m_tready stays high; an item is held in the input
// register, the register update and result are formed on the way to the output register, which
// presents the result. the output register lets a new item be taken while
// a result waits; the input side stalls only when both registers hold items and m_tready
// is low. there is no clearing pass after reset. sample bits at or above BUTTON_COUNT are
// ignored and those buttons always read as zero.
module button_edge_latch_register_block
  import btn_edge_pkg::*;
#(
  parameter int BUTTON_COUNT = DEFAULT_BUTTON_COUNT
) (
  input  logic                  clk,
  input  logic                  rst,
  // input item
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // button_sample, lamp_word_in, active_word_in, byte_count, zero pad
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // operation
  input  logic [OP_W-1:0]       s_tuser,
  // result item
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // state_out, pressed_out, released_out, lamp_word_out, active_word_out,
  // old_lamp_word, old_active_word, lamp_update, irq_pending, zero pad
  output logic [OUT_DATA_W-1:0] m_tdata
);

  // input register
  logic                    in_valid;
  logic [OP_W-1:0]         in_op;
  logic [BUTTON_COUNT-1:0] in_sample;
  logic [WORD_W-1:0]       in_lamp;
  logic [WORD_W-1:0]       in_active;
  logic [COUNT_W-1:0]      in_count;

  // register block state, button registers only as wide as the button count
  logic [BUTTON_COUNT-1:0] stable_buttons, stable_buttons_next;
  logic [BUTTON_COUNT-1:0] rise_latch, rise_latch_next;
  logic [BUTTON_COUNT-1:0] fall_latch, fall_latch_next;
  logic [WORD_W-1:0]       lamp_word, lamp_word_next;
  logic [WORD_W-1:0]       active_word, active_word_next;
  logic [WORD_W-1:0]       prior_lamp, prior_lamp_next;
  logic [WORD_W-1:0]       prior_active, prior_active_next;
  logic                    update_flag, update_flag_next;
  logic                    irq_flag, irq_flag_next;

  logic [BUTTON_COUNT-1:0] rep_rise, rep_fall;
  logic [WORD_W-1:0]       write_active;
  logic [OUT_DATA_W-1:0]   result;
  logic                    advance;

  // the output register can take the item in the input register
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op     <= s_tuser;
      in_sample <= s_tdata[BUTTON_COUNT-1:0];
      in_lamp   <= s_tdata[2*WORD_W-1:WORD_W];
      in_active <= s_tdata[3*WORD_W-1:2*WORD_W];
      in_count  <= s_tdata[3*WORD_W+COUNT_W-1:3*WORD_W];
    end
  end

  // two- and three-byte writes keep the active word
  assign write_active = (in_count >= FULL_BYTES) ? in_active : active_word;

  always_comb begin
    stable_buttons_next = stable_buttons;
    rise_latch_next     = rise_latch;
    fall_latch_next     = fall_latch;
    lamp_word_next      = lamp_word;
    active_word_next    = active_word;
    prior_lamp_next     = prior_lamp;
    prior_active_next   = prior_active;
    update_flag_next    = update_flag;
    irq_flag_next       = irq_flag;
    rep_rise            = rise_latch;
    rep_fall            = fall_latch;
    case (op_t'(in_op))
      OP_SCAN: begin
        if (in_sample != stable_buttons) begin
          rise_latch_next     = rise_latch | (in_sample & ~stable_buttons);
          fall_latch_next     = fall_latch | (~in_sample & stable_buttons);
          stable_buttons_next = in_sample;
          irq_flag_next       = 1'b1;
        end
        // a scan reports the latches after the edge update
        rep_rise = rise_latch_next;
        rep_fall = fall_latch_next;
      end
      OP_READ: begin
        rise_latch_next = '0;
        fall_latch_next = '0;
        irq_flag_next   = 1'b0;
      end
      OP_WRITE: begin
        // short writes change nothing, unchanged words change nothing
        if (in_count >= LAMP_BYTES &&
            (in_lamp != lamp_word || write_active != active_word)) begin
          prior_lamp_next   = lamp_word;
          prior_active_next = active_word;
          lamp_word_next    = in_lamp;
          active_word_next  = write_active;
          update_flag_next  = 1'b1;
        end
      end
      OP_ACK: begin
        update_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result = '0;
    result[WORD_W-1:0]          = WORD_W'(stable_buttons_next);
    result[2*WORD_W-1:WORD_W]   = WORD_W'(rep_rise);
    result[3*WORD_W-1:2*WORD_W] = WORD_W'(rep_fall);
    result[4*WORD_W-1:3*WORD_W] = lamp_word_next;
    result[5*WORD_W-1:4*WORD_W] = active_word_next;
    result[6*WORD_W-1:5*WORD_W] = prior_lamp_next;
    result[7*WORD_W-1:6*WORD_W] = prior_active_next;
    result[7*WORD_W]            = update_flag_next;
    result[7*WORD_W+1]          = irq_flag_next;
  end

  // state moves when the item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_buttons <= '0;
      rise_latch     <= '0;
      fall_latch     <= '0;
      lamp_word      <= '0;
      active_word    <= '0;
      prior_lamp     <= '0;
      prior_active   <= '0;
      update_flag    <= 1'b0;
      irq_flag       <= 1'b0;
    end else if (in_valid && advance) begin
      stable_buttons <= stable_buttons_next;
      rise_latch     <= rise_latch_next;
      fall_latch     <= fall_latch_next;
      lamp_word      <= lamp_word_next;
      active_word    <= active_word_next;
      prior_lamp     <= prior_lamp_next;
      prior_active   <= prior_active_next;
      update_flag    <= update_flag_next;
      irq_flag       <= irq_flag_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      m_tdata <= result;
    end
  end

endmodule

// File: src/btn_edge_checker.sv
// port-level checker for the button edge latch register block, with its bind
module btn_edge_checker
  import btn_edge_pkg::*;
#(
  parameter int BUTTON_COUNT = DEFAULT_BUTTON_COUNT
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  localparam logic [WORD_W-1:0] UNUSED =
    ~WORD_W'((17'(1) << BUTTON_COUNT) - 17'(1));

  // a result waiting on the master keeps its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed or vanished while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // an empty output register always leaves room on the input side
  a_room: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // buttons beyond the button count never show up
  a_unused_buttons: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[WORD_W-1:0] & UNUSED) == '0) &&
                 ((m_tdata[2*WORD_W-1:WORD_W] & UNUSED) == '0) &&
                 ((m_tdata[3*WORD_W-1:2*WORD_W] & UNUSED) == '0))
    else $error("unused button bit set in result");

endmodule

bind button_edge_latch_register_block btn_edge_checker #(
  .BUTTON_COUNT(BUTTON_COUNT)
) u_btn_edge_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/button_edge_latch_register_block_tb.sv
// self-checking testbench for the button edge latch register block
module button_edge_latch_register_block_tb
  import btn_edge_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUTTONS = DEFAULT_BUTTON_COUNT;
  localparam logic [WORD_W-1:0] BUTTON_MASK =
    (BUTTONS >= WORD_W) ? {WORD_W{1'b1}} : WORD_W'((1 << BUTTONS) - 1);
  localparam int ITEMS_PER_PHASE = 300;
  localparam int DRAIN_CYCLES = 8;

  // full register view of one result item, msb first so it lines up with m_tdata
  typedef struct packed {
    logic              irq;
    logic              upd;
    logic [WORD_W-1:0] old_active;
    logic [WORD_W-1:0] old_lamp;
    logic [WORD_W-1:0] active;
    logic [WORD_W-1:0] lamp;
    logic [WORD_W-1:0] released;
    logic [WORD_W-1:0] pressed;
    logic [WORD_W-1:0] levels;
  } panel_view_t;

  typedef struct packed {
    op_t                op;
    logic [WORD_W-1:0]  sample;
    logic [WORD_W-1:0]  lamp;
    logic [WORD_W-1:0]  active;
    logic [COUNT_W-1:0] count;
    bit                 typed;
    panel_view_t        want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [OP_W-1:0]       s_tuser = OP_SCAN;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  button_edge_latch_register_block #(
    .BUTTON_COUNT(BUTTONS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted register contents
  logic [WORD_W-1:0] held_levels = '0;
  logic [WORD_W-1:0] pressed_sticky = '0;
  logic [WORD_W-1:0] released_sticky = '0;
  logic [WORD_W-1:0] lamp_now = '0;
  logic [WORD_W-1:0] active_now = '0;
  logic [WORD_W-1:0] lamp_saved = '0;
  logic [WORD_W-1:0] active_saved = '0;
  logic              update_pending = 1'b0;
  logic              irq_raised = 1'b0;

  panel_view_t expected_views[$];
  stim_row_t   directed_rows[$];
  int          send_idle_pct = 35;
  int          recv_idle_pct = 75;
  int          mismatches = 0;
  int          results_seen = 0;
  int          op_counts[4] = '{0, 0, 0, 0};

  function automatic panel_view_t mk_view(
    input logic [WORD_W-1:0] levels, pressed, released, lamp, active, old_lamp, old_active,
    input logic upd, irq
  );
    panel_view_t v;
    v.levels = levels;
    v.pressed = pressed;
    v.released = released;
    v.lamp = lamp;
    v.active = active;
    v.old_lamp = old_lamp;
    v.old_active = old_active;
    v.upd = upd;
    v.irq = irq;
    return v;
  endfunction

  // advance the predicted registers by one operation and return the view it reports
  task automatic apply_panel_op(
    input op_t op, input logic [WORD_W-1:0] sample, lamp, active,
    input logic [COUNT_W-1:0] count, output panel_view_t v
  );
    logic [WORD_W-1:0] lv;
    logic [WORD_W-1:0] new_active;
    logic [WORD_W-1:0] rep_pressed;
    logic [WORD_W-1:0] rep_released;
    lv = sample & BUTTON_MASK;
    if (op == OP_SCAN && lv != held_levels) begin
      pressed_sticky |= lv & ~held_levels;
      released_sticky |= ~lv & held_levels;
      held_levels = lv;
      irq_raised = 1'b1;
    end
    rep_pressed = pressed_sticky;
    rep_released = released_sticky;
    case (op)
      OP_READ: begin
        pressed_sticky = '0;
        released_sticky = '0;
        irq_raised = 1'b0;
      end
      OP_WRITE: begin
        if (count >= LAMP_BYTES) begin
          new_active = (count >= FULL_BYTES) ? active : active_now;
          if (lamp != lamp_now || new_active != active_now) begin
            lamp_saved = lamp_now;
            active_saved = active_now;
            lamp_now = lamp;
            active_now = new_active;
            update_pending = 1'b1;
          end
        end
      end
      OP_ACK: update_pending = 1'b0;
      default: ;
    endcase
    v = mk_view(held_levels, rep_pressed, rep_released, lamp_now, active_now,
                lamp_saved, active_saved, update_pending, irq_raised);
  endtask

  task automatic add_row(
    input op_t op, input logic [WORD_W-1:0] sample, lamp, active,
    input logic [COUNT_W-1:0] count, input bit typed, input panel_view_t want
  );
    stim_row_t r;
    r.op = op;
    r.sample = sample;
    r.lamp = lamp;
    r.active = active;
    r.count = count;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endtask

  // present one item, wait for it to be taken, then queue what it should report
  task automatic send_op(
    input op_t op, input logic [WORD_W-1:0] sample, lamp, active,
    input logic [COUNT_W-1:0] count, input bit typed, input panel_view_t want
  );
    panel_view_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= IN_DATA_W'({count, active, lamp, sample});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    apply_panel_op(op, sample, lamp, active, count, pred);
    expected_views.push_back(typed ? want : pred);
    op_counts[op]++;
  endtask

  // hold the sender off until every queued view has come back
  task automatic wait_all_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_items(input int n);
    int                 pick;
    op_t                op;
    logic [WORD_W-1:0]  sample;
    logic [WORD_W-1:0]  lamp;
    logic [WORD_W-1:0]  active;
    logic [COUNT_W-1:0] count;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 40) op = OP_SCAN;
      else if (pick < 60) op = OP_READ;
      else if (pick < 88) op = OP_WRITE;
      else op = OP_ACK;
      // repeated levels, single button toggles and random patterns
      pick = $urandom_range(99);
      if (pick < 25) sample = held_levels;
      else if (pick < 60) sample = held_levels ^ (WORD_W'(1) << $urandom_range(WORD_W - 1));
      else sample = WORD_W'($urandom);
      lamp = ($urandom_range(99) < 30) ? lamp_now : WORD_W'($urandom);
      active = ($urandom_range(99) < 30) ? active_now : WORD_W'($urandom);
      count = COUNT_W'($urandom_range(7));
      send_op(op, sample, lamp, active, count, 1'b0, '0);
    end
  endtask

  task automatic report_field(input string name, input logic [WORD_W-1:0] want, got);
    $error("%s mismatch: expected %h, got %h", name, want, got);
    mismatches++;
  endtask

  // result side: random stalls and in-order comparison against the queued views
  always @(posedge clk) begin
    panel_view_t got;
    panel_view_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[OUT_FIELDS_W-1:0];
      results_seen++;
      if (expected_views.size() == 0) begin
        $error("result item with no expectation waiting: %h", m_tdata);
        mismatches++;
      end else begin
        want = expected_views.pop_front();
        if (got.levels !== want.levels) report_field("state_out", want.levels, got.levels);
        if (got.pressed !== want.pressed) report_field("pressed_out", want.pressed, got.pressed);
        if (got.released !== want.released)
          report_field("released_out", want.released, got.released);
        if (got.lamp !== want.lamp) report_field("lamp_word_out", want.lamp, got.lamp);
        if (got.active !== want.active)
          report_field("active_word_out", want.active, got.active);
        if (got.old_lamp !== want.old_lamp)
          report_field("old_lamp_word", want.old_lamp, got.old_lamp);
        if (got.old_active !== want.old_active)
          report_field("old_active_word", want.old_active, got.old_active);
        if (got.upd !== want.upd) report_field("lamp_update", WORD_W'(want.upd), WORD_W'(got.upd));
        if (got.irq !== want.irq) report_field("irq_pending", WORD_W'(want.irq), WORD_W'(got.irq));
      end
    end
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    #5_000_000;
    $display("FAIL button_edge_latch_register_block");
    $finish;
  end

  initial begin
    stim_row_t r;
    // directed rows; fixed views where the outcome is plain from reset state
    add_row(OP_READ,  16'h0000, 16'h0000, 16'h0000, 3'd0, 1'b1, '0);
    add_row(OP_ACK,   16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1, '0);
    add_row(OP_WRITE, 16'h0000, 16'hFFFF, 16'hFFFF, 3'd1, 1'b1, '0);
    add_row(OP_WRITE, 16'hFFFF, 16'h1234, 16'h5678, 3'd0, 1'b1, '0);
    add_row(OP_SCAN,  16'h0000, 16'hFFFF, 16'hFFFF, 3'd4, 1'b1, '0);
    add_row(OP_SCAN,  16'hFFFF, 16'h0000, 16'h0000, 3'd0, 1'b1,
            mk_view(16'hFFFF, 16'hFFFF, 16'h0000, '0, '0, '0, '0, 1'b0, 1'b1));
    add_row(OP_SCAN,  16'hFFFF, 16'h0000, 16'h0000, 3'd0, 1'b1,
            mk_view(16'hFFFF, 16'hFFFF, 16'h0000, '0, '0, '0, '0, 1'b0, 1'b1));
    add_row(OP_SCAN,  16'h0000, 16'h0000, 16'h0000, 3'd0, 1'b1,
            mk_view(16'h0000, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0, 1'b0, 1'b1));
    add_row(OP_READ,  16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7, 1'b1,
            mk_view(16'h0000, 16'hFFFF, 16'hFFFF, '0, '0, '0, '0, 1'b0, 1'b0));
    add_row(OP_READ,  16'h0000, 16'h0000, 16'h0000, 3'd0, 1'b1, '0);
    add_row(OP_WRITE, 16'hFFFF, 16'hFFFF, 16'h1234, 3'd2, 1'b1,
            mk_view('0, '0, '0, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0));
    add_row(OP_WRITE, 16'h0000, 16'hFFFF, 16'hFFFF, 3'd4, 1'b1,
            mk_view('0, '0, '0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b1, 1'b0));
    // unchanged write with an oversized count, then acknowledge
    add_row(OP_WRITE, 16'h0000, 16'hFFFF, 16'hFFFF, 3'd7, 1'b0, '0);
    add_row(OP_ACK,   16'h0000, 16'h0000, 16'h0000, 3'd0, 1'b0, '0);
    add_row(OP_ACK,   16'h0000, 16'h0000, 16'h0000, 3'd0, 1'b0, '0);
    add_row(OP_WRITE, 16'h0000, 16'h0000, 16'h5555, 3'd3, 1'b0, '0);
    add_row(OP_WRITE, 16'h0000, 16'h0000, 16'h0000, 3'd5, 1'b0, '0);
    add_row(OP_WRITE, 16'h0000, 16'hA5A5, 16'h5A5A, 3'd6, 1'b0, '0);
    add_row(OP_SCAN,  16'hA5A5, 16'h0000, 16'h0000, 3'd0, 1'b0, '0);
    add_row(OP_SCAN,  16'h5A5A, 16'hFFFF, 16'hFFFF, 3'd7, 1'b0, '0);
    add_row(OP_SCAN,  16'h8001, 16'h0000, 16'h0000, 3'd0, 1'b0, '0);
    add_row(OP_READ,  16'h0000, 16'h0000, 16'h0000, 3'd0, 1'b0, '0);
    add_row(OP_ACK,   16'h0000, 16'h0000, 16'h0000, 3'd0, 1'b0, '0);
    add_row(OP_WRITE, 16'h7FFE, 16'h0001, 16'h8000, 3'd4, 1'b0, '0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_op(r.op, r.sample, r.lamp, r.active, r.count, r.typed, r.want);
    end
    wait_all_results();

    send_random_items(ITEMS_PER_PHASE);
    wait_all_results();

    send_idle_pct = 75;
    recv_idle_pct = 35;
    send_random_items(ITEMS_PER_PHASE);
    wait_all_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_items(ITEMS_PER_PHASE);
    wait_all_results();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_views.size() != 0) begin
      $error("%0d expected result items never arrived", expected_views.size());
      mismatches++;
    end
    $display("run covered %0d scans, %0d reads, %0d writes, %0d acknowledges",
             op_counts[OP_SCAN], op_counts[OP_READ], op_counts[OP_WRITE], op_counts[OP_ACK]);
    $display("%0d result items compared under three stall patterns, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("PASS button_edge_latch_register_block");
    end else begin
      $display("FAIL button_edge_latch_register_block");
    end
    $finish;
  end

endmodule
